>>> src/tlb_lfu_pkg.sv
// Shared types, constants and control structs of the page-translate TLB block.
package tlb_lfu_pkg;

	localparam int VA_BITS      = 16;
	localparam int OFFSET_BITS  = 8;
	localparam int VPAGE_BITS   = VA_BITS - OFFSET_BITS;
	localparam int FRAME_OUT_BITS = 8;
	localparam int HITS_BITS    = 32;
	localparam int FAULTS_BITS  = 9;
	localparam int IN_BYTES_BITS  = 16;
	localparam int OUT_BYTES_BITS = 72;

	localparam int TLB_ENTRIES_DEF = 16;
	localparam int PAGE_COUNT_DEF  = 256;
	localparam int FRAME_COUNT_DEF = 256;
	localparam int COUNT_BITS_DEF  = 16;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_LOOKUP,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic clear_wr;
		logic accept;
		logic scan_issue;
		logic lookup;
		logic update;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic issue_last;
		logic scan_done;
		logic out_free;
	} dp_status_t;

endpackage

>>> src/tlb_page_translate_lfu.sv
// Top level of the demand-paging address translator with an LFU-replaced TLB.
//
// Each transfer on the slave side carries one 16-bit virtual address; the block
// answers with exactly one transfer on the master side. After reset the page
// table and use counts are cleared in a pass over all PAGE_COUNT entries,
// during which s_tready stays low. While the master side keeps up, an item then
// goes from acceptance to the next possible acceptance through an accept step,
// one TLB entry read per cycle with each entry's page use count coming from the
// read port of the page table memory, a drain of that read pipeline, a lookup
// read of the page table and an update that writes it back. The result waits in
// an output register, so the next address is taken while it is still pending;
// that next item then stalls in its lookup state until the pending transfer
// completes.
module tlb_page_translate_lfu #(
	parameter int TLB_ENTRIES = tlb_lfu_pkg::TLB_ENTRIES_DEF,
	parameter int PAGE_COUNT  = tlb_lfu_pkg::PAGE_COUNT_DEF,
	parameter int FRAME_COUNT = tlb_lfu_pkg::FRAME_COUNT_DEF,
	parameter int COUNT_BITS  = tlb_lfu_pkg::COUNT_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// virtual_address[15:0]
	input  logic [tlb_lfu_pkg::IN_BYTES_BITS-1:0]  s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// physical_address[15:0], mapped_frame[23:16], tlb_hit[24], fault_flag[25],
	// hit_total[57:26], fault_total[66:58], zero fill above
	output logic [tlb_lfu_pkg::OUT_BYTES_BITS-1:0] m_tdata
);

	import tlb_lfu_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	logic [VA_BITS-1:0]        physical_address;
	logic [FRAME_OUT_BITS-1:0] mapped_frame;
	logic                      tlb_hit;
	logic                      fault_flag;
	logic [HITS_BITS-1:0]      hit_total;
	logic [FAULTS_BITS-1:0]    fault_total;

	localparam int PACK_BITS = VA_BITS + FRAME_OUT_BITS + 2 + HITS_BITS + FAULTS_BITS;

	tlb_lfu_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.status  (status),
		.cmd     (cmd)
	);

	tlb_lfu_dp #(
		.TLB_ENTRIES(TLB_ENTRIES),
		.PAGE_COUNT (PAGE_COUNT),
		.FRAME_COUNT(FRAME_COUNT),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.virtual_address (s_tdata[VA_BITS-1:0]),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.physical_address(physical_address),
		.mapped_frame    (mapped_frame),
		.tlb_hit         (tlb_hit),
		.fault_flag      (fault_flag),
		.hit_total       (hit_total),
		.fault_total     (fault_total)
	);

	assign m_tdata = {{(OUT_BYTES_BITS - PACK_BITS){1'b0}}, fault_total, hit_total,
		fault_flag, tlb_hit, mapped_frame, physical_address};

endmodule

>>> src/tlb_lfu_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module tlb_lfu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  logic [WIDTH-1:0]     wr_data,
	input  logic                 rd_en,
	input  logic [ADDR_BITS-1:0] rd_addr,
	output logic [WIDTH-1:0]     rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> src/tlb_lfu_ctrl.sv
// Controller state machine sequencing the clear pass, TLB scan, lookup and update.
module tlb_lfu_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  tlb_lfu_pkg::dp_status_t status,
	output tlb_lfu_pkg::ctrl_cmd_t  cmd
);

	import tlb_lfu_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (status.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (status.issue_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (status.scan_done) state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				if (status.out_free) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.accept = in_valid;
			end
			ST_SCAN: begin
				cmd.scan_issue = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_LOOKUP: begin
				cmd.lookup = status.out_free;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> src/tlb_lfu_dp.sv
// Datapath: TLB and page table storage, scan pipeline, LFU victim search and result register.
module tlb_lfu_dp #(
	parameter int TLB_ENTRIES = tlb_lfu_pkg::TLB_ENTRIES_DEF,
	parameter int PAGE_COUNT  = tlb_lfu_pkg::PAGE_COUNT_DEF,
	parameter int FRAME_COUNT = tlb_lfu_pkg::FRAME_COUNT_DEF,
	parameter int COUNT_BITS  = tlb_lfu_pkg::COUNT_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  tlb_lfu_pkg::ctrl_cmd_t                  cmd,
	output tlb_lfu_pkg::dp_status_t                 status,
	input  logic [tlb_lfu_pkg::VA_BITS-1:0]         virtual_address,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [tlb_lfu_pkg::VA_BITS-1:0]         physical_address,
	output logic [tlb_lfu_pkg::FRAME_OUT_BITS-1:0]  mapped_frame,
	output logic                                    tlb_hit,
	output logic                                    fault_flag,
	output logic [tlb_lfu_pkg::HITS_BITS-1:0]       hit_total,
	output logic [tlb_lfu_pkg::FAULTS_BITS-1:0]     fault_total
);

	import tlb_lfu_pkg::*;

	localparam int IDX_BITS   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
	localparam int PAGE_BITS  = $clog2(PAGE_COUNT);
	localparam int FRAME_BITS = $clog2(FRAME_COUNT);
	localparam int TLB_W      = PAGE_BITS + FRAME_BITS;
	localparam int PT_W       = 1 + FRAME_BITS + COUNT_BITS;
	localparam int VPAGES     = 1 << VPAGE_BITS;

	// Virtual page number folded into the page range, one entry per high address byte.
	logic [PAGE_BITS-1:0] page_fold [VPAGES];
	for (genvar v = 0; v < VPAGES; v++) begin : g_fold
		assign page_fold[v] = PAGE_BITS'(v % PAGE_COUNT);
	end

	logic [PAGE_BITS-1:0]   page_q;
	logic [OFFSET_BITS-1:0] offset_q;
	logic [PAGE_BITS-1:0]   clr_addr_q;
	logic [IDX_BITS-1:0]    idx_q;
	logic [TLB_ENTRIES-1:0] tlb_valid_q;

	logic                  v_s1;
	logic [IDX_BITS-1:0]   idx_s1;
	logic                  tv_s1;
	logic                  v_s2;
	logic [IDX_BITS-1:0]   idx_s2;
	logic                  tv_s2;
	logic [PAGE_BITS-1:0]  tpage_s2;
	logic [FRAME_BITS-1:0] tframe_s2;

	logic                  hit_q;
	logic [FRAME_BITS-1:0] hframe_q;
	logic                  empty_q;
	logic [IDX_BITS-1:0]   victim_q;
	logic [COUNT_BITS-1:0] best_q;
	logic [FRAME_BITS-1:0] nff_q;
	logic [HITS_BITS-1:0]  hits_q;
	logic [FAULTS_BITS-1:0] faults_q;

	logic [TLB_W-1:0] tlb_rd;
	logic [TLB_W-1:0] tlb_wr;
	logic [PAGE_BITS-1:0] tlb_rd_page;
	logic [FRAME_BITS-1:0] tlb_rd_frame;
	logic             tlb_we;

	logic                  pt_we;
	logic [PAGE_BITS-1:0]  pt_waddr;
	logic [PT_W-1:0]       pt_wdata;
	logic                  pt_re;
	logic [PAGE_BITS-1:0]  pt_raddr;
	logic [PT_W-1:0]       pt_rd;
	logic                  pt_valid;
	logic [FRAME_BITS-1:0] pt_frame;
	logic [COUNT_BITS-1:0] pt_count;

	logic                  fault;
	logic [FRAME_BITS-1:0] frame;
	logic [COUNT_BITS-1:0] count_inc;
	logic                  match;

	assign tlb_rd_page  = tlb_rd[TLB_W-1 -: PAGE_BITS];
	assign tlb_rd_frame = tlb_rd[FRAME_BITS-1:0];
	assign pt_valid = pt_rd[PT_W-1];
	assign pt_frame = pt_rd[COUNT_BITS +: FRAME_BITS];
	assign pt_count = pt_rd[COUNT_BITS-1:0];

	tlb_lfu_ram #(
		.WIDTH(TLB_W),
		.DEPTH(TLB_ENTRIES)
	) u_tlb_ram (
		.clk    (clk),
		.wr_en  (tlb_we),
		.wr_addr(victim_q),
		.wr_data(tlb_wr),
		.rd_en  (cmd.scan_issue),
		.rd_addr(idx_q),
		.rd_data(tlb_rd)
	);

	tlb_lfu_ram #(
		.WIDTH(PT_W),
		.DEPTH(PAGE_COUNT)
	) u_pt_ram (
		.clk    (clk),
		.wr_en  (pt_we),
		.wr_addr(pt_waddr),
		.wr_data(pt_wdata),
		.rd_en  (pt_re),
		.rd_addr(pt_raddr),
		.rd_data(pt_rd)
	);

	// During the scan the page table returns the use count of each TLB entry's page.
	assign pt_re    = v_s1 | cmd.lookup;
	assign pt_raddr = v_s1 ? tlb_rd_page : page_q;

	always_comb begin
		fault = ~hit_q & ~pt_valid;
		if (hit_q) begin
			frame = hframe_q;
		end else if (pt_valid) begin
			frame = pt_frame;
		end else begin
			frame = nff_q;
		end
		count_inc = (pt_count == '1) ? pt_count : pt_count + 1'b1;
	end

	assign pt_we    = cmd.clear_wr | cmd.update;
	assign pt_waddr = cmd.clear_wr ? clr_addr_q : page_q;
	assign pt_wdata = cmd.clear_wr ? '0 : {1'b1, frame, count_inc};
	assign tlb_we   = cmd.update & ~hit_q;
	assign tlb_wr   = {page_q, frame};
	assign match    = tv_s2 && (tpage_s2 == page_q);

	always_comb begin
		status.clear_last = (clr_addr_q == PAGE_BITS'(PAGE_COUNT - 1));
		status.issue_last = (idx_q == IDX_BITS'(TLB_ENTRIES - 1));
		status.scan_done  = v_s2 && (idx_s2 == IDX_BITS'(TLB_ENTRIES - 1));
		status.out_free   = ~out_valid | out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			idx_q       <= '0;
			tlb_valid_q <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			hit_q       <= 1'b0;
			empty_q     <= 1'b0;
			nff_q       <= '0;
			hits_q      <= '0;
			faults_q    <= '0;
			out_valid   <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_issue;
			v_s2 <= v_s1;
			if (cmd.clear_wr) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (cmd.accept) begin
				idx_q   <= '0;
				hit_q   <= 1'b0;
				empty_q <= 1'b0;
			end else if (cmd.scan_issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (v_s2) begin
				if (match && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (!tv_s2) begin
					empty_q <= 1'b1;
				end
			end
			if (cmd.update) begin
				if (!hit_q) begin
					tlb_valid_q[victim_q] <= 1'b1;
				end
				if (fault) begin
					nff_q <= (nff_q == FRAME_BITS'(FRAME_COUNT - 1)) ? '0 : nff_q + 1'b1;
				end
			end
			if (cmd.update) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (cmd.update && hit_q && (hits_q != '1)) begin
				hits_q <= hits_q + 1'b1;
			end
			if (cmd.update && fault && (faults_q != '1)) begin
				faults_q <= faults_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			page_q   <= page_fold[virtual_address[VA_BITS-1 -: VPAGE_BITS]];
			offset_q <= virtual_address[OFFSET_BITS-1:0];
		end
		if (cmd.scan_issue) begin
			idx_s1 <= idx_q;
			tv_s1  <= tlb_valid_q[idx_q];
		end
		if (v_s1) begin
			idx_s2    <= idx_s1;
			tv_s2     <= tv_s1;
			tpage_s2  <= tlb_rd_page;
			tframe_s2 <= tlb_rd_frame;
		end
		if (v_s2) begin
			if (match && !hit_q) begin
				hframe_q <= tframe_s2;
			end
			// The first empty slot wins; otherwise the lowest count, later slots winning ties.
			if (!tv_s2) begin
				if (!empty_q) begin
					victim_q <= idx_s2;
				end
			end else if ((idx_s2 == '0) || (pt_count <= best_q)) begin
				best_q <= pt_count;
				if (!empty_q) begin
					victim_q <= idx_s2;
				end
			end
		end
		if (cmd.update) begin
			physical_address <= {FRAME_OUT_BITS'(frame), offset_q};
			mapped_frame     <= FRAME_OUT_BITS'(frame);
			tlb_hit          <= hit_q;
			fault_flag       <= fault;
			hit_total        <= (hit_q && (hits_q != '1)) ? hits_q + 1'b1 : hits_q;
			fault_total      <= (fault && (faults_q != '1)) ? faults_q + 1'b1 : faults_q;
		end
	end

endmodule
